FILE: rtl/core/mqg_pkg.sv
// Shared types and constants for the mouse quadrature generator.
// No dependencies; imported by mqg_axis and mouse_quadrature_generator.
package mqg_pkg;

  // Width of the signed pending motion count of each axis.
  localparam int COUNT_WIDTH = 16;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  // Limits of the wrapped position difference, on the 10-bit raw difference.
  localparam logic signed [9:0] DIFF_HALF = 10'sd128;
  localparam logic signed [9:0] DIFF_SPAN = 10'sd256;

  // Bit positions in the port byte.
  localparam int BIT_X_DIR  = 0;
  localparam int BIT_X_CLK  = 1;
  localparam int BIT_Y_DIR  = 2;
  localparam int BIT_Y_CLK  = 3;
  localparam int BIT_BUTTON = 7;

  localparam logic [7:0] PORT_RESET = 8'hFF;

  // Quadrature outputs of one axis.
  typedef struct packed {
    logic dir;
    logic clk;
  } axis_bits_t;

endpackage

FILE: rtl/core/mqg_axis.sv
// One axis of the mouse quadrature generator: last position, pending count
// and the next clock and direction bits. Depends on mqg_pkg.
module mqg_axis (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         pos,
  input  mqg_pkg::axis_bits_t bits_cur,
  output mqg_pkg::axis_bits_t bits_next
);
  import mqg_pkg::*;

  logic [7:0]                    last_pos;
  logic signed [COUNT_WIDTH-1:0] pending;
  logic signed [COUNT_WIDTH-1:0] pending_next;

  logic signed [9:0]             diff_raw;
  logic signed [9:0]             diff_wrap;
  logic signed [COUNT_WIDTH:0]   sum_wide;
  logic signed [COUNT_WIDTH-1:0] sum_sat;

  always_comb begin
    diff_raw = $signed({2'b00, pos}) - $signed({2'b00, last_pos});
    if (diff_raw > DIFF_HALF) begin
      diff_wrap = diff_raw - DIFF_SPAN;
    end else if (diff_raw < -DIFF_HALF) begin
      diff_wrap = diff_raw + DIFF_SPAN;
    end else begin
      diff_wrap = diff_raw;
    end

    // The wrapped difference fits in 9 bits; extend it to the sum width.
    sum_wide = $signed({pending[COUNT_WIDTH-1], pending})
             + $signed({{(COUNT_WIDTH-8){diff_wrap[8]}}, diff_wrap[8:0]});

    // The top two bits differ only when the sum left the count's range.
    if (sum_wide[COUNT_WIDTH] != sum_wide[COUNT_WIDTH-1]) begin
      sum_sat = sum_wide[COUNT_WIDTH] ? COUNT_MIN : COUNT_MAX;
    end else begin
      sum_sat = sum_wide[COUNT_WIDTH-1:0];
    end

    pending_next = sum_sat;
    bits_next    = bits_cur;
    if (sum_sat != '0) begin
      bits_next.clk = ~bits_cur.clk;
      if (sum_sat[COUNT_WIDTH-1]) begin
        pending_next = sum_sat + COUNT_WIDTH'(1);
        if (bits_next.clk) begin
          bits_next.dir = 1'b0;
        end
      end else begin
        pending_next = sum_sat - COUNT_WIDTH'(1);
        if (bits_next.clk) begin
          bits_next.dir = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos <= '0;
      pending  <= '0;
    end else if (step) begin
      last_pos <= pos;
      pending  <= pending_next;
    end
  end

endmodule

FILE: rtl/core/mouse_quadrature_generator.sv
// Mouse quadrature generator top level: input register, two axis units and
// the port byte, which doubles as the result register. Depends on mqg_pkg, mqg_axis.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   input   | in_valid/in_ready, pos_x,    | in
//           | pos_y, button                |
//   result  | out_valid/out_ready,         | out
//           | port_value                   |
//
// An item is held in the input register and then moves into the result register,
// from which its result is offered on the output until it is taken; the move
// happens only when the result register is empty or its result is being taken.
// One item is taken per cycle while the result is not stalled.
// Reset clears both stages, the positions and counts; the port byte reads 0xFF.
// A stalled result holds the input register; a new item is still taken when
// the input register moves forward in the same cycle.
module mouse_quadrature_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic       button,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] port_value
);
  import mqg_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_pos_x;
  logic [7:0] stage_pos_y;
  logic       stage_button;
  logic       advance;

  logic [7:0] port_image;
  logic [7:0] port_image_next;

  axis_bits_t x_cur, x_next, y_cur, y_next;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_pos_x  <= pos_x;
      stage_pos_y  <= pos_y;
      stage_button <= button;
    end
  end

  assign x_cur.dir = port_image[BIT_X_DIR];
  assign x_cur.clk = port_image[BIT_X_CLK];
  assign y_cur.dir = port_image[BIT_Y_DIR];
  assign y_cur.clk = port_image[BIT_Y_CLK];

  mqg_axis u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .pos      (stage_pos_x),
    .bits_cur (x_cur),
    .bits_next(x_next)
  );

  mqg_axis u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .pos      (stage_pos_y),
    .bits_cur (y_cur),
    .bits_next(y_next)
  );

  always_comb begin
    port_image_next             = port_image;
    port_image_next[BIT_BUTTON] = !stage_button;
    port_image_next[BIT_X_DIR]  = x_next.dir;
    port_image_next[BIT_X_CLK]  = x_next.clk;
    port_image_next[BIT_Y_DIR]  = y_next.dir;
    port_image_next[BIT_Y_CLK]  = y_next.clk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      port_image <= PORT_RESET;
    end else if (advance) begin
      out_valid  <= 1'b1;
      port_image <= port_image_next;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  assign port_value = port_image;

  // The unused bits of the port byte never leave their reset value.
  a_spare_bits: assert property (@(posedge clk) disable iff (rst)
    port_image[6:4] == 3'b111)
    else $error("spare port bits changed");

  // The port byte, and with it the axis state, moves only with an item.
  a_hold_image: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(port_image))
    else $error("port byte changed without an item");

  // A processed item always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");

  // The button bit is the inverted button of the item just processed.
  a_button_level: assert property (@(posedge clk) disable iff (rst)
    advance |=> port_image[BIT_BUTTON] == !$past(stage_button))
    else $error("button bit mismatch");

  // An empty input register never refuses an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("input refused while empty");

endmodule
